// ----- rtl/utf8_char_frequency_scorer_macros.svh -----
// ----------------------------------------------------------------------------
// UTF-8 character frequency scorer: assertion macros
// Concurrent checks on the block clock, turned off for synthesis.
// ----------------------------------------------------------------------------
`ifndef UTF8_CHAR_FREQUENCY_SCORER_MACROS_SVH
`define UTF8_CHAR_FREQUENCY_SCORER_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define UCFS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ucfs invariant violated");
// Check a consequence in the same cycle.
`define UCFS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ucfs implication violated");
// Check a consequence in the next cycle.
`define UCFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ucfs next-cycle check violated");
`else
`define UCFS_ASSERT_ALWAYS(lbl, cond)
`define UCFS_ASSERT_IMPL(lbl, ante, cons)
`define UCFS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/ucfs_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 character frequency scorer: shared package
// Command codes, byte masks, table entry type and lead byte decode.
// ----------------------------------------------------------------------------
package ucfs_pkg;

  localparam logic [1:0] CMD_LOAD_ENTRY = 2'd0;
  localparam logic [1:0] CMD_LOAD_GROUP = 2'd1;
  localparam logic [1:0] CMD_DATA       = 2'd2;

  localparam int         NUM_GROUPS     = 17;
  localparam logic [4:0] GROUP_LIMIT    = 5'd17;
  localparam logic [4:0] TWO_BYTE_GROUP = 5'd16;

  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD4_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_MASK = 8'hC0;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  // Character lengths decoded from a lead byte; five marks a stray byte.
  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;
  localparam logic [2:0] LEN_STRAY = 3'd5;

  localparam logic [23:0] RATIO_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  score;
  } tbl_entry_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] n;
    if (b <= ASCII_MAX) begin
      n = LEN_ONE;
    end else if ((b & LEAD4_MASK) == LEAD4_MASK) begin
      n = LEN_FOUR;
    end else if ((b & LEAD3_MASK) == LEAD3_MASK) begin
      n = LEN_THREE;
    end else if ((b & LEAD2_MASK) == LEAD2_MASK) begin
      n = LEN_TWO;
    end else begin
      n = LEN_STRAY;
    end
    return n;
  endfunction

endpackage

// ----- rtl/ucfs_item_if.sv -----
// ----------------------------------------------------------------------------
// UTF-8 character frequency scorer: input channel
// Valid/ready channel carrying table loads, group bounds and text bytes.
// ----------------------------------------------------------------------------
interface ucfs_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] entry_index;
  logic [15:0] entry_key;
  logic [7:0]  entry_score;
  logic [4:0]  group_select;
  logic [11:0] group_start;
  logic [12:0] group_length;
  logic [7:0]  data_byte;
  logic        last;
  logic [2:0]  omit_count;

  modport source (
    output valid, cmd, entry_index, entry_key, entry_score, group_select,
           group_start, group_length, data_byte, last, omit_count,
    input  ready
  );
  modport sink (
    input  valid, cmd, entry_index, entry_key, entry_score, group_select,
           group_start, group_length, data_byte, last, omit_count,
    output ready
  );
endinterface

// ----- rtl/ucfs_result_if.sv -----
// ----------------------------------------------------------------------------
// UTF-8 character frequency scorer: result channel
// Valid/ready channel carrying the totals of one text run.
// ----------------------------------------------------------------------------
interface ucfs_result_if;
  logic        valid;
  logic        ready;
  logic [20:0] score_total;
  logic [13:0] char_count;
  logic [23:0] ratio;

  modport source (output valid, score_total, char_count, ratio, input ready);
  modport sink   (input valid, score_total, char_count, ratio, output ready);
endinterface

// ----- rtl/ucfs_table.sv -----
// ----------------------------------------------------------------------------
// UTF-8 character frequency scorer: frequency table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ucfs_table #(
  parameter int DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  ucfs_pkg::tbl_entry_t          wdata,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output ucfs_pkg::tbl_entry_t          rdata
);

  ucfs_pkg::tbl_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/utf8_char_frequency_scorer.sv -----
// ----------------------------------------------------------------------------
// UTF-8 character frequency scorer: a load or plain byte is handled in IDLE alone.
// A byte that ends a 2- or 3-byte character runs a binary search through PROBE and COMPARE.
// A last byte adds a restoring division over a dividend of score width + 16 bits.
// Rate is set by the table read port and the one shared subtractor.
// Sync reset clears run state and group bounds; the table needs no clear.
// ----------------------------------------------------------------------------
`include "utf8_char_frequency_scorer_macros.svh"

// Operation
//   cmd load entry : write key and score into the table (address wraps).
//   cmd load group : write first address and length of one of 17 groups.
//   cmd data byte  : advance the UTF-8 decoder. A lead byte sets how many
//                    continuation bytes follow. When the final byte of a
//                    two- or three-byte character arrives, binary search
//                    its 16-bit key in its group, add the hit score and
//                    bump the character count, both saturating.
//   A data byte with last set ends the run: totals and
//   score * 65536 / (count + omit) go out through the output register,
//   then the run state clears. A character cut off by last is dropped.
//
// Sequencer
//   IDLE    take one transfer; ready is high only here.
//   PROBE   check the window [lo, hi1); issue one table read at its middle.
//   COMPARE compare the read key with the search key in the shared unit; narrow the window.
//   FINISH  accumulate score and count.
//   SETUP   prepare the restoring divider.
//   DIV     one quotient bit per cycle through the shared unit.
//   DONE    park the result in the output register once it is free.
//
// The output register decouples the sides: the next run's bytes are taken
// while an earlier result still waits for its transfer.
module utf8_char_frequency_scorer #(
  parameter int TABLE_DEPTH = 4096,   // power of two
  parameter int MAX_BYTES   = 16384
) (
  input  logic          clk,
  input  logic          rst,
  ucfs_item_if.sink     item,
  ucfs_result_if.source result
);

  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_LIMIT = MAX_BYTES / 2;
  localparam int SCORE_LIMIT = 255 * COUNT_LIMIT;
  localparam int CNT_W       = $clog2(COUNT_LIMIT + 1);
  localparam int SUM_W       = $clog2(SCORE_LIMIT + 1);
  localparam int DIV_W       = $clog2(COUNT_LIMIT + 8);
  localparam int DVD_W       = SUM_W + 16;
  localparam int OP_W        = (DIV_W + 1 > 16) ? DIV_W + 1 : 16;
  localparam int STEP_W      = $clog2(DVD_W + 1);
  localparam int PROBE_EXT   = ADDR_W + 14;
  localparam int INDEX_EXT   = ADDR_W + 12;
  localparam int SUM_EXT     = SUM_W + 21;
  localparam int CNT_EXT     = CNT_W + 14;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_FINISH,
    ST_SETUP,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;

  // Run state
  logic [2:0]       skip;
  logic [23:0]      char_bytes;
  logic [1:0]       char_len;
  logic [SUM_W-1:0] score_sum;
  logic [CNT_W-1:0] chars_seen;
  logic             pend_last;
  logic [2:0]       omit;

  // Group bounds
  logic [11:0] group_base [ucfs_pkg::NUM_GROUPS];
  logic [12:0] group_size [ucfs_pkg::NUM_GROUPS];

  // Search registers
  logic [15:0] search_key;
  logic [11:0] search_base;
  logic [12:0] lo;
  logic [12:0] hi1;
  logic [12:0] probe_mid;
  logic [7:0]  hit_score;

  // Divider registers
  logic [DIV_W-1:0]  divisor;
  logic [DIV_W-1:0]  rem;
  logic [DVD_W-1:0]  dividend;
  logic [23:0]       quot;
  logic              quot_ovf;
  logic [STEP_W-1:0] step;

  // Output register
  logic        out_valid;
  logic [20:0] out_score;
  logic [13:0] out_count;
  logic [23:0] out_ratio;

  // Table memory
  logic                 tbl_we;
  logic [ADDR_W-1:0]    tbl_waddr;
  logic [ADDR_W-1:0]    tbl_raddr;
  ucfs_pkg::tbl_entry_t tbl_wdata;
  ucfs_pkg::tbl_entry_t tbl_rdata;
  logic [INDEX_EXT-1:0] index_wide;

  assign index_wide       = INDEX_EXT'(item.entry_index);
  assign tbl_waddr        = index_wide[ADDR_W-1:0];
  assign tbl_wdata.key    = item.entry_key;
  assign tbl_wdata.score  = item.entry_score;
  assign tbl_we = (state == ST_IDLE) && item.valid &&
                  (item.cmd == ucfs_pkg::CMD_LOAD_ENTRY);

  ucfs_table #(.DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Probe address: middle of the window, offset by the group base, wrapped.
  logic [13:0]          mid_sum;
  logic [12:0]          mid;
  logic [PROBE_EXT-1:0] probe_wide;

  assign mid_sum    = 14'(lo) + 14'(hi1) - 14'd1;
  assign mid        = mid_sum[13:1];
  assign probe_wide = PROBE_EXT'(search_base) + PROBE_EXT'(mid);
  assign tbl_raddr  = probe_wide[ADDR_W-1:0];

  // Shared subtractor: key compare during search, trial subtract in division.
  logic [DIV_W:0]  rem_shift;
  logic [OP_W-1:0] sub_a;
  logic [OP_W-1:0] sub_b;
  logic [OP_W:0]   sub_diff;
  logic            sub_borrow;
  logic            sub_zero;

  assign rem_shift = {rem, dividend[DVD_W-1]};

  always_comb begin
    if (state == ST_DIV) begin
      sub_a = OP_W'(rem_shift);
      sub_b = OP_W'(divisor);
    end else begin
      sub_a = OP_W'(search_key);
      sub_b = OP_W'(tbl_rdata.key);
    end
  end

  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[OP_W];
  assign sub_zero   = (sub_diff[OP_W-1:0] == '0);

  // Byte decode
  logic [2:0]  lead_len;
  logic [23:0] bytes_shifted;
  logic [4:0]  char_group;

  assign lead_len      = ucfs_pkg::lead_length(item.data_byte);
  assign bytes_shifted = {char_bytes[15:0], item.data_byte};
  assign char_group    = (char_len == 2'(ucfs_pkg::LEN_TWO)) ? ucfs_pkg::TWO_BYTE_GROUP
                                                            : {1'b0, bytes_shifted[19:16]};

  // Saturating accumulate
  logic [SUM_W:0] sum_add;
  assign sum_add = (SUM_W+1)'(score_sum) + (SUM_W+1)'(hit_score);

  // Output field views of the run totals
  logic [SUM_EXT-1:0] sum_wide;
  logic [CNT_EXT-1:0] cnt_wide;
  assign sum_wide = SUM_EXT'(score_sum);
  assign cnt_wide = CNT_EXT'(chars_seen);

  assign item.ready         = (state == ST_IDLE);
  assign result.valid       = out_valid;
  assign result.score_total = out_score;
  assign result.char_count  = out_count;
  assign result.ratio       = out_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      skip       <= 3'd0;
      char_bytes <= 24'd0;
      char_len   <= 2'd0;
      score_sum  <= '0;
      chars_seen <= '0;
      pend_last  <= 1'b0;
      for (int g = 0; g < ucfs_pkg::NUM_GROUPS; g++) begin
        group_base[g] <= 12'd0;
        group_size[g] <= 13'd0;
      end
    end else begin
      // Drop the result once its transfer completes, unless DONE parks the
      // next one in the same cycle.
      if (result.valid && result.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (item.valid) begin
            case (item.cmd)
              ucfs_pkg::CMD_LOAD_GROUP: begin
                if (item.group_select < ucfs_pkg::GROUP_LIMIT) begin
                  group_base[item.group_select] <= item.group_start;
                  group_size[item.group_select] <= item.group_length;
                end
              end
              ucfs_pkg::CMD_DATA: begin
                pend_last <= item.last;
                omit      <= item.omit_count;
                if (skip == 3'd0) begin
                  // Lead byte; on the last byte it is not examined.
                  if (!item.last) begin
                    if (lead_len == ucfs_pkg::LEN_TWO || lead_len == ucfs_pkg::LEN_THREE) begin
                      char_len   <= lead_len[1:0];
                      char_bytes <= 24'(item.data_byte);
                    end
                    skip <= lead_len - 3'd1;
                  end else begin
                    state <= ST_SETUP;
                  end
                end else begin
                  skip <= skip - 3'd1;
                  if (char_len != 2'd0 && skip == 3'd1) begin
                    // Character complete: start the search in its group.
                    char_bytes  <= bytes_shifted;
                    search_key  <= bytes_shifted[15:0];
                    search_base <= group_base[char_group];
                    lo          <= 13'd0;
                    hi1         <= group_size[char_group];
                    state       <= ST_PROBE;
                  end else begin
                    if (char_len != 2'd0) begin
                      char_bytes <= bytes_shifted;
                    end
                    if (item.last) begin
                      state <= ST_SETUP;
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end

        ST_PROBE: begin
          if (lo < hi1) begin
            probe_mid <= mid;
            state     <= ST_COMPARE;
          end else begin
            hit_score <= 8'd0;
            state     <= ST_FINISH;
          end
        end

        ST_COMPARE: begin
          if (sub_zero) begin
            hit_score <= tbl_rdata.score;
            state     <= ST_FINISH;
          end else if (sub_borrow) begin
            hi1   <= probe_mid;
            state <= ST_PROBE;
          end else begin
            lo    <= probe_mid + 13'd1;
            state <= ST_PROBE;
          end
        end

        ST_FINISH: begin
          if (sum_add > (SUM_W+1)'(SCORE_LIMIT)) begin
            score_sum <= SUM_W'(SCORE_LIMIT);
          end else begin
            score_sum <= sum_add[SUM_W-1:0];
          end
          if (chars_seen < CNT_W'(COUNT_LIMIT)) begin
            chars_seen <= chars_seen + CNT_W'(1);
          end
          char_len   <= 2'd0;
          char_bytes <= 24'd0;
          state      <= pend_last ? ST_SETUP : ST_IDLE;
        end

        ST_SETUP: begin
          quot     <= 24'd0;
          quot_ovf <= 1'b0;
          if (chars_seen == '0) begin
            state <= ST_DONE;
          end else begin
            divisor  <= DIV_W'(chars_seen) + DIV_W'(omit);
            rem      <= '0;
            dividend <= {score_sum, 16'd0};
            step     <= STEP_W'(DVD_W);
            state    <= ST_DIV;
          end
        end

        ST_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (sub_borrow) begin
            rem <= rem_shift[DIV_W-1:0];
          end else begin
            rem <= sub_diff[DIV_W-1:0];
          end
          quot     <= {quot[22:0], ~sub_borrow};
          quot_ovf <= quot_ovf | quot[23];
          dividend <= {dividend[DVD_W-2:0], 1'b0};
          step     <= step - STEP_W'(1);
          if (step == STEP_W'(1)) begin
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          // Hold until the output register is free, then clear the run.
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_score  <= sum_wide[20:0];
            out_count  <= cnt_wide[13:0];
            out_ratio  <= quot_ovf ? ucfs_pkg::RATIO_MAX : quot;
            skip       <= 3'd0;
            char_bytes <= 24'd0;
            char_len   <= 2'd0;
            score_sum  <= '0;
            chars_seen <= '0;
            state      <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Data byte flagged last, taken this cycle
  logic data_last_taken;
  assign data_last_taken = item.valid && item.ready && item.last &&
                           (item.cmd == ucfs_pkg::CMD_DATA);

  `UCFS_ASSERT_ALWAYS(a_count_saturates, chars_seen <= CNT_W'(COUNT_LIMIT))
  `UCFS_ASSERT_ALWAYS(a_sum_saturates, score_sum <= SUM_W'(SCORE_LIMIT))
  `UCFS_ASSERT_IMPL(a_rem_below_divisor, state == ST_DIV, rem < divisor)
  `UCFS_ASSERT_IMPL(a_idle_no_partial, state == ST_IDLE && skip == 3'd0, char_len == 2'd0)
  `UCFS_ASSERT_NEXT(a_last_holds_input, data_last_taken, !item.ready)

endmodule
